[src/cst_pkg.sv]
// cst_pkg: shared types and constants of the sparse transpose block.
// Used by csr_sparse_transpose_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;
  localparam int MAX_NONZERO = 1024;
  localparam int MAX_DIM     = 256;
  localparam int NZ_AW       = $clog2(MAX_NONZERO);
  localparam int NZ_CW       = $clog2(MAX_NONZERO + 1);
  localparam int DIM_AW      = $clog2(MAX_DIM);
  localparam int DIM_CW      = $clog2(MAX_DIM + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  src_row;
    logic [7:0]  src_col;
    logic [63:0] value_bits;
  } in_req_t;

  typedef struct packed {
    logic        valid_res;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
    logic [63:0] out_value;
    logic        last;
    logic        dropped;
  } out_res_t;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [63:0] value;
  } entry_t;
endpackage
`default_nettype wire

[src/cst_ram.sv]
// cst_ram: generic single-port-write, single-read synchronous RAM.
// Registered read data, valid in the cycle after the read address; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cst_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/csr_sparse_transpose_top.sv]
// csr_sparse_transpose_top: sparse matrix transpose by counting sort.
// Load: each request is accepted, its counter is read, then incremented and written back.
// Drain: each request steps through the order read, entry read and output states
// and the result is registered; the next request is taken only after the receiver
// accepts the result. The first drain runs a prefix-sum sweep over the counters,
// then scatters each loaded entry. Synchronous reset; the counters are cleared
// by a sweep over all MAX_DIM counters after reset and after the last entry,
// during which no request is accepted. Depends on cst_pkg and cst_ram.
`timescale 1ns / 1ps
`default_nettype none
module csr_sparse_transpose_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cst_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cst_pkg::out_res_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [8:0]        cfg_wdata
);
  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LRD   = 11'b00000000100,
    S_LWR   = 11'b00000001000,
    S_PSUM  = 11'b00000010000,
    S_SRD   = 11'b00000100000,
    S_SCOL  = 11'b00001000000,
    S_SWR   = 11'b00010000000,
    S_DRD   = 11'b00100000000,
    S_DENT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [8:0] num_cols_r;
  cst_pkg::in_req_t req_r;
  logic [cst_pkg::NZ_CW-1:0]  loaded_r, loaded_nxt, pos_r, pos_nxt;
  logic [cst_pkg::DIM_CW-1:0] sweep_r, sweep_nxt;
  logic [cst_pkg::NZ_CW-1:0]  run_r, run_nxt;
  logic draining_r, draining_nxt, dropped_r, dropped_nxt;
  logic out_valid_r;
  cst_pkg::out_res_t res_r, res_nxt;
  logic out_load;

  // counter memory: holds counts, then reused as the scatter cursors
  logic                        cnt_we;
  logic [cst_pkg::DIM_AW-1:0]  cnt_waddr, cnt_raddr;
  logic [cst_pkg::NZ_CW-1:0]   cnt_wdata, cnt_rdata;
  cst_ram #(.DEPTH(cst_pkg::MAX_DIM), .WIDTH(cst_pkg::NZ_CW)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));

  logic                       ent_we;
  logic [cst_pkg::NZ_AW-1:0]  ent_waddr, ent_raddr;
  cst_pkg::entry_t            ent_rdata;
  cst_ram #(.DEPTH(cst_pkg::MAX_NONZERO), .WIDTH($bits(cst_pkg::entry_t))) u_ent (
    .clk, .we(ent_we), .waddr(ent_waddr),
    .wdata({req_r.src_row, req_r.src_col, req_r.value_bits}),
    .raddr(ent_raddr), .rdata(ent_rdata));

  logic                       ord_we;
  logic [cst_pkg::NZ_AW-1:0]  ord_waddr, ord_raddr;
  logic [cst_pkg::NZ_AW-1:0]  ord_rdata;
  cst_ram #(.DEPTH(cst_pkg::MAX_NONZERO), .WIDTH(cst_pkg::NZ_AW)) u_ord (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(pos_r[cst_pkg::NZ_AW-1:0]),
    .raddr(ord_raddr), .rdata(ord_rdata));

  logic [cst_pkg::DIM_CW-1:0] limit;
  logic in_acc;
  logic ld_ok;

  assign limit = (num_cols_r > 9'(cst_pkg::MAX_DIM)) ? cst_pkg::DIM_CW'(cst_pkg::MAX_DIM)
                                                      : cst_pkg::DIM_CW'(num_cols_r);
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign out_load  = out_valid_r && out_ready;
  assign ld_ok = !draining_r && (cst_pkg::DIM_CW'(req_r.src_col) < limit) &&
                 (loaded_r < cst_pkg::NZ_CW'(cst_pkg::MAX_NONZERO));

  always_comb begin
    state_nxt    = state_r;
    loaded_nxt   = loaded_r;
    pos_nxt      = pos_r;
    sweep_nxt    = sweep_r;
    run_nxt      = run_r;
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    res_nxt      = res_r;
    cnt_we = 1'b0; cnt_waddr = sweep_r[cst_pkg::DIM_AW-1:0]; cnt_wdata = '0;
    cnt_raddr = req_r.src_col[cst_pkg::DIM_AW-1:0];
    ent_we = 1'b0; ent_waddr = loaded_r[cst_pkg::NZ_AW-1:0];
    ent_raddr = pos_r[cst_pkg::NZ_AW-1:0];
    ord_we = 1'b0; ord_waddr = '0; ord_raddr = pos_r[cst_pkg::NZ_AW-1:0];
    case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == cst_pkg::DIM_CW'(cst_pkg::MAX_DIM - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == cst_pkg::OP_LOAD) state_nxt = S_LRD;
          else if (loaded_r == '0) begin
            res_nxt = '0;
            res_nxt.dropped = dropped_r;
          end else if (!draining_r) begin
            sweep_nxt = '0; run_nxt = '0; state_nxt = S_PSUM;
          end else state_nxt = S_DRD;
        end
      end
      S_LRD: begin
        if (ld_ok) state_nxt = S_LWR;
        else begin
          dropped_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_LWR: begin
        cnt_we = 1'b1;
        cnt_waddr = req_r.src_col[cst_pkg::DIM_AW-1:0];
        cnt_wdata = cnt_rdata + 1'b1;
        ent_we = 1'b1;
        loaded_nxt = loaded_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_PSUM: begin
        // read counter sweep, write back exclusive running sum one behind
        cnt_raddr = sweep_r[cst_pkg::DIM_AW-1:0];
        if (sweep_r != '0) begin
          cnt_we = 1'b1;
          cnt_waddr = cst_pkg::DIM_AW'(sweep_r - 1'b1);
          cnt_wdata = run_r;
          run_nxt = run_r + cnt_rdata;
        end
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == cst_pkg::DIM_CW'(cst_pkg::MAX_DIM)) begin
          pos_nxt = '0; state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        ent_raddr = pos_r[cst_pkg::NZ_AW-1:0];
        state_nxt = S_SCOL;
      end
      S_SCOL: begin
        cnt_raddr = ent_rdata.col[cst_pkg::DIM_AW-1:0];
        state_nxt = S_SWR;
      end
      S_SWR: begin
        // cursor bump and order scatter; one entry at a time, no overlap
        cnt_we = 1'b1;
        cnt_waddr = ent_rdata.col[cst_pkg::DIM_AW-1:0];
        cnt_wdata = cnt_rdata + 1'b1;
        ord_we = 1'b1;
        ord_waddr = cnt_rdata[cst_pkg::NZ_AW-1:0];
        pos_nxt = pos_r + 1'b1;
        if (pos_r + 1'b1 == loaded_r) begin
          pos_nxt = '0; draining_nxt = 1'b1; state_nxt = S_DRD;
        end else state_nxt = S_SRD;
      end
      S_DRD: begin
        ord_raddr = pos_r[cst_pkg::NZ_AW-1:0];
        state_nxt = S_DENT;
      end
      S_DENT: begin
        ent_raddr = ord_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_nxt.valid_res = 1'b1;
        res_nxt.out_row   = ent_rdata.col;
        res_nxt.out_col   = ent_rdata.row;
        res_nxt.out_value = ent_rdata.value;
        res_nxt.last      = (pos_r + 1'b1 >= loaded_r);
        res_nxt.dropped   = dropped_r;
        if (pos_r + 1'b1 >= loaded_r) begin
          loaded_nxt = '0; pos_nxt = '0; draining_nxt = 1'b0;
          sweep_nxt = '0; state_nxt = S_CLR;
        end else begin
          pos_nxt = pos_r + 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  logic res_fire;
  assign res_fire = (state_r == S_OUT) ||
                    (in_acc && in_data.op == cst_pkg::OP_DRAIN && loaded_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      num_cols_r <= 9'd256;
      loaded_r <= '0; pos_r <= '0; sweep_r <= '0; run_r <= '0;
      draining_r <= 1'b0; dropped_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) num_cols_r <= cfg_wdata;
      loaded_r <= loaded_nxt; pos_r <= pos_nxt; sweep_r <= sweep_nxt;
      run_r <= run_nxt; draining_r <= draining_nxt; dropped_r <= dropped_nxt;
      if (res_fire) out_valid_r <= 1'b1;
      else if (out_load) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) req_r <= in_data;
    res_r <= res_nxt;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("request accepted with result pending");
  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(dropped_r) && $past(rst_n) |-> dropped_r) else $error("dropped flag cleared");
  a_loaded_cap: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= cst_pkg::NZ_CW'(cst_pkg::MAX_NONZERO)) else $error("fill count overflow");
endmodule
`default_nettype wire
